FILE: hdl/lrs_pkg.sv
package lrs_pkg;

    localparam int ROW_BITS       = 64;
    localparam int CFG_BITS       = 7;
    localparam int GRID_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 4;
    localparam int NBR_BITS       = 4;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

    // B3/S23 neighbour counts
    localparam logic [NBR_BITS-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_BITS-1:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_row;
        logic                frame_end;
    } t_result;

    typedef struct packed {
        logic a;
        logic b;
    } t_push;

endpackage

FILE: hdl/lrs_in_if.sv
interface lrs_in_if import lrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_cells;
    logic                last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

FILE: hdl/lrs_out_if.sv
interface lrs_out_if import lrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] next_row;
    logic                frame_end;

    modport source (output valid, output next_row, output frame_end, input ready);
    modport sink   (input valid, input next_row, input frame_end, output ready);
endinterface

FILE: hdl/lrs_lane.sv
module lrs_lane import lrs_pkg::*; (
    input  logic [2:0] i_up,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_down,
    output logic       o_next
);

    logic [NBR_BITS-1:0] nbr_cnt;

    assign nbr_cnt = NBR_BITS'(i_up[0]) + NBR_BITS'(i_up[1]) + NBR_BITS'(i_up[2])
                   + NBR_BITS'(i_mid[0]) + NBR_BITS'(i_mid[2])
                   + NBR_BITS'(i_down[0]) + NBR_BITS'(i_down[1]) + NBR_BITS'(i_down[2]);

    always_comb begin
        if (nbr_cnt == BIRTH_COUNT) begin
            o_next = 1'b1;
        end else if (nbr_cnt == SURVIVE_COUNT) begin
            o_next = i_mid[1];
        end else begin
            o_next = 1'b0;
        end
    end

endmodule

FILE: hdl/lrs_row_engine.sv
module lrs_row_engine import lrs_pkg::*; #(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF
) (
    input  logic [GRID_WIDTH-1:0] i_up,
    input  logic [GRID_WIDTH-1:0] i_mid,
    input  logic [GRID_WIDTH-1:0] i_down,
    input  logic [GRID_WIDTH-1:0] i_mask,
    output logic [GRID_WIDTH-1:0] o_row
);

    // dead column padded on both sides, cells beyond the width masked off
    logic [GRID_WIDTH+1:0] up_pad;
    logic [GRID_WIDTH+1:0] mid_pad;
    logic [GRID_WIDTH+1:0] down_pad;
    logic [GRID_WIDTH-1:0] lane_out;

    assign up_pad   = {1'b0, i_up & i_mask, 1'b0};
    assign mid_pad  = {1'b0, i_mid & i_mask, 1'b0};
    assign down_pad = {1'b0, i_down & i_mask, 1'b0};

    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_lane
        lrs_lane u_lane (
            .i_up   (up_pad[c+2:c]),
            .i_mid  (mid_pad[c+2:c]),
            .i_down (down_pad[c+2:c]),
            .o_next (lane_out[c])
        );
    end

    assign o_row = lane_out & i_mask;

endmodule

FILE: hdl/lrs_out_queue.sv
module lrs_out_queue import lrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  t_result   i_word_a,
    input  t_result   i_word_b,
    output logic      o_room,
    lrs_out_if.source o_out
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_result         r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;
    logic [PW:0]     n_cnt;
    logic [PW-1:0]   wp_next;
    logic [PW:0]     push_n;
    logic            pop;
    t_result         head;

    assign wp_next = r_wp + PW'(1);
    assign push_n  = (PW+1)'(i_push.a) + (PW+1)'(i_push.b);
    assign pop     = o_out.valid && o_out.ready;

    assign n_wp  = r_wp + push_n[PW-1:0];
    assign n_rp  = r_rp + PW'(pop);
    assign n_cnt = r_cnt + push_n - (PW+1)'(pop);

    // room for the two words a bottom row can bring
    assign o_room = r_cnt <= (PW+1)'(QUEUE_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a) begin
            r_mem[r_wp] <= i_word_a;
        end
        if (i_push.b) begin
            r_mem[i_push.a ? wp_next : r_wp] <= i_word_b;
        end
    end

    assign head            = r_mem[r_rp];
    assign o_out.valid     = r_cnt != '0;
    assign o_out.next_row  = head.next_row;
    assign o_out.frame_end = head.frame_end;

endmodule

FILE: hdl/life_rule_row_stencil_core.sv
// Row stencil for the B3/S23 cellular automaton.
// i_in carries one grid row per word (bit i is column i) plus last_row,
// which marks the bottom row. o_out carries next-generation rows with
// frame_end set on the bottom row's result. i_cfg_we/i_cfg_data set the
// grid width (columns_in_use); write it only while the block is idle.
// Every row after the first of a frame yields the result for the row
// above it; the bottom row yields one more for itself, so a frame of N
// rows gives N words. A row's words are computed on the accepting edge
// and queue up in a 4-word output buffer, whose head word drives o_out.
// Throughput is one row per cycle while the buffer has room: all columns
// are evaluated at once by one lane per column, and the buffer drains one
// word per cycle while o_out.ready is high.
// i_in.ready drops only while the buffer lacks room for two words, e.g.
// when the receiver holds o_out.ready low.
// Reset (synchronous, active low) empties the buffer, clears held rows
// and restores the width to 64 columns.
module life_rule_row_stencil_core import lrs_pkg::*; #(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    lrs_in_if.sink              i_in,
    lrs_out_if.source           o_out
);

    logic [CFG_BITS-1:0]   r_cols;
    logic [GRID_WIDTH-1:0] r_above;
    logic [GRID_WIDTH-1:0] r_middle;
    logic [1:0]            r_seen;

    logic [CFG_BITS-1:0]   live_w;
    logic [GRID_WIDTH-1:0] mask;
    logic [GRID_WIDTH-1:0] in_row;
    logic [GRID_WIDTH-1:0] row_a;
    logic [GRID_WIDTH-1:0] row_b;
    logic                  accept;
    logic                  room;
    t_push                 push;
    t_result               word_a;
    t_result               word_b;

    assign live_w = (r_cols > CFG_BITS'(GRID_WIDTH)) ? CFG_BITS'(GRID_WIDTH) : r_cols;

    for (genvar i = 0; i < GRID_WIDTH; i++) begin : g_mask
        assign mask[i] = CFG_BITS'(i) < live_w;
    end

    assign in_row = i_in.row_cells[GRID_WIDTH-1:0] & mask;
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = room;

    // pending row with the new row below it
    lrs_row_engine #(.GRID_WIDTH(GRID_WIDTH)) u_eng_a (
        .i_up   (r_above),
        .i_mid  (r_middle),
        .i_down (in_row),
        .i_mask (mask),
        .o_row  (row_a)
    );

    // bottom row with a dead row below; held middle row is zero on a frame's first row
    lrs_row_engine #(.GRID_WIDTH(GRID_WIDTH)) u_eng_b (
        .i_up   (r_middle),
        .i_mid  (in_row),
        .i_down ('0),
        .i_mask (mask),
        .o_row  (row_b)
    );

    assign push.a           = accept && (r_seen != 2'd0);
    assign push.b           = accept && i_in.last_row;
    assign word_a.next_row  = ROW_BITS'(row_a);
    assign word_a.frame_end = 1'b0;
    assign word_b.next_row  = ROW_BITS'(row_b);
    assign word_b.frame_end = 1'b1;

    lrs_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word_a (word_a),
        .i_word_b (word_b),
        .o_room   (room),
        .o_out    (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= CFG_RESET;
            r_above  <= '0;
            r_middle <= '0;
            r_seen   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_cols <= i_cfg_data;
            end
            if (accept) begin
                if (i_in.last_row) begin
                    r_above  <= '0;
                    r_middle <= '0;
                    r_seen   <= 2'd0;
                end else begin
                    r_above  <= r_middle;
                    r_middle <= in_row;
                    r_seen   <= (r_seen == 2'd0) ? 2'd1 : 2'd2;
                end
            end
        end
    end

endmodule
